// ===== hdl/adq_pkg.sv =====
// shared types and constants for the array deque with index read
`timescale 1ns / 1ps
`default_nettype none

package adq_pkg;

	localparam int ADQ_CAPACITY = 16;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_READ       = 3'd4;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;
	localparam logic [1:0] STS_RANGE = 2'd3;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
		logic [3:0]         position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_data;
		logic [4:0]         count;
		logic [1:0]         status;
	} rsp_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_READ
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_now;
		logic load_mem;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mem_read;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/adq_ctrl.sv =====
// controller state machine for the array deque
`timescale 1ns / 1ps
`default_nettype none

module adq_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	input  adq_pkg::dp_sts_t sts,
	output adq_pkg::dp_cmd_t cmd
);
	import adq_pkg::*;

	state_t state_q, state_nxt;
	logic   rsp_valid_q, rsp_valid_nxt;
	logic   can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rsp_valid_q <= rsp_valid_nxt;
		end
	end

	always_comb begin
		can_load      = !rsp_valid_q || !rsp_stall;
		state_nxt     = state_q;
		req_stall     = 1'b1;
		cmd           = '0;
		rsp_valid_nxt = rsp_valid_q && rsp_stall;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = !can_load;
				if (req_valid && can_load) begin
					cmd.accept = 1'b1;
					if (sts.mem_read) begin
						state_nxt = ST_READ;
					end else begin
						cmd.load_now  = 1'b1;
						rsp_valid_nxt = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.load_mem  = 1'b1;
				rsp_valid_nxt = 1'b1;
				state_nxt     = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !rsp_valid_q)
		else $error("output register busy while memory data arrives");

	a_read_goes_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.mem_read) |=> (state_q == ST_READ))
		else $error("in-range read did not enter the read wait state");

	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (rsp_valid_q && state_q == ST_IDLE))
		else $error("read result not loaded after memory access");

endmodule

`default_nettype wire

// ===== hdl/adq_dp.sv =====
// datapath: pointers, count, circular store and response register
`timescale 1ns / 1ps
`default_nettype none

module adq_dp #(
	parameter int CAPACITY = adq_pkg::ADQ_CAPACITY
) (
	input  wire              clk,
	input  wire              arst_n,
	input  adq_pkg::req_t    req,
	input  adq_pkg::dp_cmd_t cmd,
	output adq_pkg::dp_sts_t sts,
	output adq_pkg::rsp_t    rsp
);
	import adq_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

	logic [31:0]      store_q [CAPACITY];
	logic [31:0]      rdata_s1;
	logic [IDX_W-1:0] front_q, front_nxt;
	logic [CNT_W-1:0] count_q, count_nxt;
	rsp_t             rsp_q;

	logic             full, empty, in_range;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr, rd_addr, front_dec;
	logic [1:0]       status;

	function automatic logic [IDX_W-1:0] wrap(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] off);
		logic [IDX_W:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IDX_W+1)'(CAPACITY))
			s = s - (IDX_W+1)'(CAPACITY);
		return s[IDX_W-1:0];
	endfunction

	always_comb begin
		full      = (count_q == CNT_W'(CAPACITY));
		empty     = (count_q == '0);
		in_range  = (CMP_W'(req.position) < CMP_W'(count_q));
		front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
		rd_addr   = wrap(front_q, IDX_W'(req.position));
		front_nxt = front_q;
		count_nxt = count_q;
		wr_en     = 1'b0;
		wr_addr   = front_dec;
		status    = STS_OK;
		case (req.command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status = STS_FULL;
				end else begin
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
					wr_en     = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				wr_addr = wrap(front_q, IDX_W'(count_q));
				if (full) begin
					status = STS_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
					wr_en     = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status = STS_EMPTY;
				end else begin
					front_nxt = wrap(front_q, IDX_W'(1));
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty)
					status = STS_EMPTY;
				else
					count_nxt = count_q - 1'b1;
			end
			CMD_READ: begin
				if (!in_range)
					status = STS_RANGE;
			end
			default: begin
			end
		endcase
		sts.mem_read = (req.command == CMD_READ) && in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (cmd.accept && wr_en)
			store_q[wr_addr] <= req.value;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && sts.mem_read)
			rdata_s1 <= store_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_now) begin
			rsp_q.read_data <= '0;
			rsp_q.count     <= 5'(count_nxt);
			rsp_q.status    <= status;
		end else if (cmd.load_mem) begin
			rsp_q.read_data <= rdata_s1;
			rsp_q.count     <= 5'(count_q);
			rsp_q.status    <= STS_OK;
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < (IDX_W+1)'(CAPACITY))
		else $error("front pointer outside the store");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_now && cmd.load_mem))
		else $error("two sources load the response register");

endmodule

`default_nettype wire

// ===== hdl/array_deque_with_index_read_core.sv =====
// top level of the array deque with index read
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of CAPACITY signed 32-bit words in a circular store.
// Each request pushes or pops at either end, or reads the word at a logical
// position from the front, and returns one response with the read word (zero
// unless a successful read), the count after the request and a status (ok,
// full on push, empty on pop, position out of range on read). A push, pop,
// failed read or unused command has its response in the output register the
// cycle after acceptance, and a new request can be taken every cycle while
// the consumer keeps up. A read that hits a stored word goes through the
// read wait state, because the store has one registered read port; no
// request is taken in that state. The count field is five bits wide and
// holds the low bits of the count when CAPACITY exceeds 31. Words are
// never cleared; only pushed entries are ever read back.
module array_deque_with_index_read_core #(
	parameter int CAPACITY = adq_pkg::ADQ_CAPACITY
) (
	input  wire           clk,
	input  wire           arst_n,
	// request channel
	input  wire           req_valid,
	output logic          req_stall,
	input  adq_pkg::req_t req,
	// response channel
	output logic          rsp_valid,
	input  wire           rsp_stall,
	output adq_pkg::rsp_t rsp
);
	import adq_pkg::*;

	// command and status between controller and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing of requests and the response register valid
	adq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// pointer math, store and response payload
	adq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== tb/adq_checker.sv =====
// response checker with its own deque predictor for the array deque core
`timescale 1ns / 1ps

module adq_checker (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	input  wire           req_stall,
	input  adq_pkg::req_t req,
	input  wire           rsp_valid,
	input  wire           rsp_stall,
	input  adq_pkg::rsp_t rsp,
	output int            errors,
	output int            pending
);

	import adq_pkg::*;

	logic signed [31:0] words [ADQ_CAPACITY];
	int                 head = 0;
	int                 held = 0;
	int                 fail_count = 0;
	rsp_t               awaited_q [$];

	// apply one request to the predicted deque and return its response
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		res = '0;
		res.status = STS_OK;
		case (r.command)
			CMD_PUSH_FRONT: begin
				if (held >= ADQ_CAPACITY) begin
					res.status = STS_FULL;
				end else begin
					head = (head + ADQ_CAPACITY - 1) % ADQ_CAPACITY;
					words[head] = r.value;
					held++;
				end
			end
			CMD_PUSH_BACK: begin
				if (held >= ADQ_CAPACITY) begin
					res.status = STS_FULL;
				end else begin
					words[(head + held) % ADQ_CAPACITY] = r.value;
					held++;
				end
			end
			CMD_POP_FRONT: begin
				if (held == 0) begin
					res.status = STS_EMPTY;
				end else begin
					head = (head + 1) % ADQ_CAPACITY;
					held--;
				end
			end
			CMD_POP_BACK: begin
				if (held == 0) begin
					res.status = STS_EMPTY;
				end else begin
					held--;
				end
			end
			CMD_READ: begin
				if (int'(r.position) >= held) begin
					res.status = STS_RANGE;
				end else begin
					res.read_data = words[(head + int'(r.position)) % ADQ_CAPACITY];
				end
			end
			default: begin
			end
		endcase
		res.count = 5'(held);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			head = 0;
			held = 0;
			awaited_q.delete();
		end else begin
			// a response always belongs to an earlier request, so compare first
			if (rsp_valid && !rsp_stall) begin
				if (awaited_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected response: data %0d count %0d status %0d",
						$time, rsp.read_data, rsp.count, rsp.status);
				end else begin
					want = awaited_q.pop_front();
					if (rsp.read_data !== want.read_data) begin
						fail_count++;
						$display("%0t: read_data expected %0d actual %0d",
							$time, want.read_data, rsp.read_data);
					end
					if (rsp.count !== want.count) begin
						fail_count++;
						$display("%0t: count expected %0d actual %0d",
							$time, want.count, rsp.count);
					end
					if (rsp.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (req_valid && !req_stall) begin
				awaited_q.insert(awaited_q.size(), apply_request(req));
			end
		end
		errors  <= fail_count;
		pending <= awaited_q.size();
	end

endmodule

// ===== tb/tb_array_deque_with_index_read_core.sv =====
// testbench top for the array deque core: stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module tb_array_deque_with_index_read_core;

	import adq_pkg::*;

	// command codes the block treats as no operation
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam int RANDOM_BLOCKS  = 22;
	localparam int BLOCK_LEN      = 25;
	localparam int HOLD_AT        = 200;   // response count at which the long stall starts
	localparam int HOLD_CYCLES    = 150;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	int errors;
	int pending;
	int idle_cycles = 0;
	bit sender_idle;
	bit receiver_idle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	array_deque_with_index_read_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	adq_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	// offer one request, optionally after a random gap, and hold it until taken
	task automatic send_req(input logic [2:0] cmd, input logic signed [31:0] val,
		input logic [3:0] pos);
		int gap;
		gap = sender_idle ? $urandom_range(0, 6) : 0;
		// valid only drops when a gap is drawn, so back-to-back requests keep it high
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req       <= '{command: cmd, value: val, position: pos};
		req_valid <= 1'b1;
		do @(posedge clk); while (!(req_valid && !req_stall));
	endtask

	// stimulus: directed corner cases, then blocks of fill, drain and mixed traffic
	initial begin : stimulus
		int                 blk;
		int                 k;
		int                 mode;
		int                 roll;
		int                 push_pct;
		int                 pop_pct;
		int                 sel;
		int                 spare;
		logic [2:0]         cmd;
		logic signed [31:0] val;
		logic [3:0]         pos;

		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		sender_idle = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: read out of range, pops flagged empty
		send_req(CMD_READ, 0, 4'd0);
		send_req(CMD_POP_FRONT, 0, 4'd0);
		send_req(CMD_POP_BACK, 0, 4'd0);
		// spare codes do nothing
		for (spare = int'(CMD_SPARE_FIRST); spare <= int'(CMD_SPARE_LAST); spare++)
			send_req(3'(spare), 32'sh7fffffff, 4'd15);
		// push extremes at both ends, front push wraps the head below zero
		send_req(CMD_PUSH_FRONT, 32'sh7fffffff, 4'd0);
		send_req(CMD_PUSH_BACK, 32'sh80000000, 4'd0);
		send_req(CMD_PUSH_FRONT, -32'sd1, 4'd0);
		send_req(CMD_PUSH_BACK, 32'sd0, 4'd0);
		send_req(CMD_READ, 0, 4'd0);
		send_req(CMD_READ, 0, 4'd1);
		send_req(CMD_READ, 0, 4'd2);
		send_req(CMD_READ, 0, 4'd3);
		// first position past the end, and the highest position
		send_req(CMD_READ, 0, 4'd4);
		send_req(CMD_READ, 0, 4'd15);
		send_req(CMD_POP_BACK, 0, 4'd0);
		send_req(CMD_POP_FRONT, 0, 4'd0);
		send_req(CMD_READ, 0, 4'd0);
		send_req(CMD_READ, 0, 4'd1);
		send_req(CMD_POP_FRONT, 0, 4'd0);
		send_req(CMD_POP_BACK, 0, 4'd0);
		send_req(CMD_POP_FRONT, 0, 4'd0);
		send_req(CMD_PUSH_BACK, 32'sh5a5aa5a5, 4'd0);
		send_req(CMD_READ, 0, 4'd0);

		// random part: the first two blocks fill the store so full pushes show up early
		for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			mode        = (blk < 2) ? 0 : $urandom_range(0, 2);
			sender_idle = ($urandom_range(0, 3) != 0);
			case (mode)
				0: begin
					push_pct = 70;
					pop_pct  = 10;
				end
				1: begin
					push_pct = 10;
					pop_pct  = 70;
				end
				default: begin
					push_pct = 35;
					pop_pct  = 35;
				end
			endcase
			for (k = 0; k < BLOCK_LEN; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < push_pct)
					cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				else if (roll < push_pct + pop_pct)
					cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
				else if (roll < 97)
					cmd = CMD_READ;
				else
					cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
				// mostly random words, now and then the extremes
				sel = $urandom_range(0, 9);
				if (sel == 0)
					val = 32'sh7fffffff;
				else if (sel == 1)
					val = 32'sh80000000;
				else
					val = $urandom;
				// lean toward low positions so reads hit stored words often
				pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 7)) : 4'($urandom);
				send_req(cmd, val, pos);
			end
		end
		req_valid <= 1'b0;

		// let the checker count the last request, then wait for every awaited response
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS array_deque_with_index_read_core");
		else
			$display("FAIL array_deque_with_index_read_core");
		$finish;
	end

	// consumer: random stall before each response, plus one long hold-off
	// that backs the block up until it stalls the request side
	initial begin : consumer
		int served;
		int wait_cycles;
		served        = 0;
		receiver_idle = 1'b0;
		rsp_stall     = 1'b0;
		forever begin
			if (served % 40 == 0)
				receiver_idle = ($urandom_range(0, 3) != 0);
			if (served == HOLD_AT)
				wait_cycles = HOLD_CYCLES;
			else
				wait_cycles = receiver_idle ? $urandom_range(0, 6) : 0;
			if (wait_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			do @(posedge clk); while (!(rsp_valid && !rsp_stall));
			served++;
		end
	end

	// watchdog: too long with no request or response taken means a hang
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL array_deque_with_index_read_core");
			$finish;
		end
	end

endmodule
